>>> sv/dmsl_pkg.sv
// Shared types and constants for the dual motor synchronized lift controller.
// Holds the request and result structs, drive and phase codes and register indexes.
// No dependencies.
package dmsl_pkg;

	typedef struct packed {
		logic up_key_held;
		logic down_key_held;
		logic up_key_edge;
		logic down_key_edge;
		logic first_top_hit;
		logic first_bottom_hit;
		logic second_top_hit;
		logic second_bottom_hit;
		logic first_pulse;
		logic second_pulse;
	} req_t;

	typedef struct packed {
		logic [1:0] first_drive;
		logic [1:0] second_drive;
		logic       raise_lamp;
		logic       lower_lamp;
		logic [1:0] phase;
	} rsp_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_RAISE = 4'b0010,
		PH_LOWER = 4'b0100,
		PH_BRAKE = 4'b1000
	} phase_t;

	localparam logic [1:0] DRV_STOP  = 2'd0;
	localparam logic [1:0] DRV_RAISE = 2'd1;
	localparam logic [1:0] DRV_LOWER = 2'd2;

	localparam logic [1:0] PHASE_IDLE  = 2'd0;
	localparam logic [1:0] PHASE_RAISE = 2'd1;
	localparam logic [1:0] PHASE_LOWER = 2'd2;
	localparam logic [1:0] PHASE_BRAKE = 2'd3;

	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SYNC_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BRAKE_TICKS    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd2;

	localparam logic [15:0] SYNC_THRESHOLD_RESET = 16'd10;
	localparam logic [15:0] BRAKE_TICKS_RESET    = 16'd100;
	localparam logic [7:0]  DEBOUNCE_TICKS_RESET = 8'd5;

endpackage

>>> sv/dual_motor_sync_lift_controller.sv
// Top level of the dual motor synchronized lift controller.
// Depends on dmsl_pkg for the request/result structs and codes.
// One request is one tick of key, limit switch and hall pulse events.
//
// Usage:
//   in_valid/in_stall/in_data carry one tick request; it is taken at a rising
//   edge with in_valid high and in_stall low. out_valid/out_stall/out_data
//   return exactly one result per request, in order: both motor drives, the
//   two lamps and the run phase.
//   cfg_wr_en/cfg_index/cfg_data write sync_threshold (0), brake_ticks (1) and
//   debounce_ticks (2); other indexes are ignored. Write only while idle.
// Pipeline:
//   A request lands in the input register, and its result is registered in the
//   output register when the output is not stalled. One request per cycle is
//   sustained while out_stall is low; the whole tick update is one pass of
//   logic from the input register to the state and output registers.
// Reset:
//   arst_n clears the run state, counts, latches and pending keys and loads
//   the register defaults (10, 100, 5). No result is pending after reset.
// Stall:
//   A stalled result holds in the output register; an empty input register
//   takes one more request, then in_stall rises until the result is taken.
module dual_motor_sync_lift_controller #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  dmsl_pkg::req_t                       in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dmsl_pkg::rsp_t                       out_data,
	input  logic                                 cfg_wr_en,
	input  logic [dmsl_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dmsl_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic [15:0]           sync_threshold_q;
	logic [15:0]           brake_ticks_q;
	logic [7:0]            debounce_ticks_q;

	logic                  valid_s1;
	dmsl_pkg::req_t        req_s1;
	logic                  advance;

	dmsl_pkg::phase_t      phase_q, phase_n;
	logic [1:0]            drive_first_q, drive_first_n;
	logic [1:0]            drive_second_q, drive_second_n;
	logic [COUNT_BITS-1:0] count_first_q, count_first_n;
	logic [COUNT_BITS-1:0] count_second_q, count_second_n;
	logic [3:0]            latches_q, latches_n;
	logic                  up_pending_q, up_pending_n;
	logic                  down_pending_q, down_pending_n;
	logic [15:0]           wait_q, wait_n;

	logic                  out_valid_q;
	dmsl_pkg::rsp_t        out_q;
	dmsl_pkg::rsp_t        rsp_n;

	function automatic logic [3:0] sync_rule(
		input logic [1:0]            dir,
		input logic                  first_lim,
		input logic                  second_lim,
		input logic [COUNT_BITS-1:0] cf,
		input logic [COUNT_BITS-1:0] cs,
		input logic [15:0]           thr,
		input logic [1:0]            d1,
		input logic [1:0]            d2
	);
		logic [COUNT_BITS-1:0] diff_fs;
		logic [COUNT_BITS-1:0] diff_sf;
		logic [1:0]            r1;
		logic [1:0]            r2;
		diff_fs = cf - cs;
		diff_sf = cs - cf;
		r1 = d1;
		r2 = d2;
		if (first_lim && second_lim) begin
			r1 = dmsl_pkg::DRV_STOP;
			r2 = dmsl_pkg::DRV_STOP;
		end else if (first_lim) begin
			r1 = dmsl_pkg::DRV_STOP;
		end else if (second_lim) begin
			r2 = dmsl_pkg::DRV_STOP;
		end else if (cf > cs && CMP_BITS'(diff_fs) > CMP_BITS'(thr)) begin
			r1 = dmsl_pkg::DRV_STOP;
			r2 = dir;
		end else if (cs > cf && CMP_BITS'(diff_sf) > CMP_BITS'(thr)) begin
			r2 = dmsl_pkg::DRV_STOP;
			r1 = dir;
		end else if (cf == cs) begin
			r1 = dir;
			r2 = dir;
		end
		return {r1, r2};
	endfunction

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_threshold_q <= dmsl_pkg::SYNC_THRESHOLD_RESET;
			brake_ticks_q    <= dmsl_pkg::BRAKE_TICKS_RESET;
			debounce_ticks_q <= dmsl_pkg::DEBOUNCE_TICKS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dmsl_pkg::REG_SYNC_THRESHOLD: sync_threshold_q <= cfg_data;
				dmsl_pkg::REG_BRAKE_TICKS:    brake_ticks_q <= cfg_data;
				dmsl_pkg::REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= in_data;
		end
	end

	always_comb begin
		logic [3:0] rule;
		logic       finish;
		logic [1:0] rev;

		rule   = '0;
		finish = 1'b0;
		rev    = dmsl_pkg::DRV_LOWER;

		phase_n        = phase_q;
		drive_first_n  = drive_first_q;
		drive_second_n = drive_second_q;
		wait_n         = wait_q;
		up_pending_n   = up_pending_q | req_s1.up_key_edge;
		down_pending_n = down_pending_q | req_s1.down_key_edge;
		latches_n      = latches_q | {req_s1.second_bottom_hit, req_s1.second_top_hit,
			req_s1.first_bottom_hit, req_s1.first_top_hit};
		count_first_n  = (req_s1.first_pulse && count_first_q != '1) ?
			count_first_q + 1'b1 : count_first_q;
		count_second_n = (req_s1.second_pulse && count_second_q != '1) ?
			count_second_q + 1'b1 : count_second_q;

		unique case (phase_q)
			dmsl_pkg::PH_IDLE: begin
				if (up_pending_n || down_pending_n) begin
					if (wait_q >= 16'(debounce_ticks_q)) begin
						wait_n = '0;
						if (up_pending_n) begin
							if (req_s1.up_key_held) begin
								phase_n = dmsl_pkg::PH_RAISE;
								rule = sync_rule(dmsl_pkg::DRV_RAISE, latches_n[0], latches_n[2],
									count_first_n, count_second_n, sync_threshold_q,
									dmsl_pkg::DRV_RAISE, dmsl_pkg::DRV_RAISE);
								drive_first_n  = rule[3:2];
								drive_second_n = rule[1:0];
							end else begin
								up_pending_n = 1'b0;
							end
						end else begin
							if (req_s1.down_key_held) begin
								phase_n = dmsl_pkg::PH_LOWER;
								rule = sync_rule(dmsl_pkg::DRV_LOWER, latches_n[1], latches_n[3],
									count_first_n, count_second_n, sync_threshold_q,
									dmsl_pkg::DRV_LOWER, dmsl_pkg::DRV_LOWER);
								drive_first_n  = rule[3:2];
								drive_second_n = rule[1:0];
							end else begin
								down_pending_n = 1'b0;
							end
						end
					end else begin
						wait_n = wait_q + 16'd1;
					end
				end else begin
					wait_n = '0;
				end
			end
			dmsl_pkg::PH_RAISE: begin
				if (!req_s1.up_key_held) begin
					up_pending_n = 1'b0;
					rev = dmsl_pkg::DRV_LOWER;
					if (brake_ticks_q == '0) begin
						finish = 1'b1;
					end else begin
						drive_first_n  = rev;
						drive_second_n = rev;
						wait_n         = brake_ticks_q;
						phase_n        = dmsl_pkg::PH_BRAKE;
					end
				end else begin
					rule = sync_rule(dmsl_pkg::DRV_RAISE, latches_n[0], latches_n[2],
						count_first_n, count_second_n, sync_threshold_q,
						drive_first_q, drive_second_q);
					drive_first_n  = rule[3:2];
					drive_second_n = rule[1:0];
				end
			end
			dmsl_pkg::PH_LOWER: begin
				if (!req_s1.down_key_held) begin
					down_pending_n = 1'b0;
					rev = dmsl_pkg::DRV_RAISE;
					if (brake_ticks_q == '0) begin
						finish = 1'b1;
					end else begin
						drive_first_n  = rev;
						drive_second_n = rev;
						wait_n         = brake_ticks_q;
						phase_n        = dmsl_pkg::PH_BRAKE;
					end
				end else begin
					rule = sync_rule(dmsl_pkg::DRV_LOWER, latches_n[1], latches_n[3],
						count_first_n, count_second_n, sync_threshold_q,
						drive_first_q, drive_second_q);
					drive_first_n  = rule[3:2];
					drive_second_n = rule[1:0];
				end
			end
			dmsl_pkg::PH_BRAKE: begin
				if (wait_q <= 16'd1) begin
					finish = 1'b1;
				end else begin
					wait_n = wait_q - 16'd1;
				end
			end
			default: begin
				phase_n = dmsl_pkg::PH_IDLE;
			end
		endcase

		if (finish) begin
			drive_first_n  = dmsl_pkg::DRV_STOP;
			drive_second_n = dmsl_pkg::DRV_STOP;
			phase_n        = dmsl_pkg::PH_IDLE;
			count_first_n  = '0;
			count_second_n = '0;
			latches_n      = '0;
			wait_n         = '0;
		end

		rsp_n.first_drive  = drive_first_n;
		rsp_n.second_drive = drive_second_n;
		rsp_n.raise_lamp   = (phase_n == dmsl_pkg::PH_RAISE);
		rsp_n.lower_lamp   = (phase_n == dmsl_pkg::PH_LOWER);
		unique case (phase_n)
			dmsl_pkg::PH_RAISE: rsp_n.phase = dmsl_pkg::PHASE_RAISE;
			dmsl_pkg::PH_LOWER: rsp_n.phase = dmsl_pkg::PHASE_LOWER;
			dmsl_pkg::PH_BRAKE: rsp_n.phase = dmsl_pkg::PHASE_BRAKE;
			default:            rsp_n.phase = dmsl_pkg::PHASE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= dmsl_pkg::PH_IDLE;
			drive_first_q  <= dmsl_pkg::DRV_STOP;
			drive_second_q <= dmsl_pkg::DRV_STOP;
			count_first_q  <= '0;
			count_second_q <= '0;
			latches_q      <= '0;
			up_pending_q   <= 1'b0;
			down_pending_q <= 1'b0;
			wait_q         <= '0;
			out_valid_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q        <= phase_n;
				drive_first_q  <= drive_first_n;
				drive_second_q <= drive_second_n;
				count_first_q  <= count_first_n;
				count_second_q <= count_second_n;
				latches_q      <= latches_n;
				up_pending_q   <= up_pending_n;
				down_pending_q <= down_pending_n;
				wait_q         <= wait_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= rsp_n;
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_motor_sync_lift_controller: table-driven directed ticks,
// a zero-lead sync and long-brake sweep, then random key sessions checked against a predictor.
// Depends on dmsl_pkg and the controller RTL.
module tb_top;

	localparam int CNT_BITS = 16;
	localparam logic [dmsl_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	localparam logic [9:0] K_UP_HELD = 10'b10_0000_0000;
	localparam logic [9:0] K_DN_HELD = 10'b01_0000_0000;
	localparam logic [9:0] K_UP_EDGE = 10'b00_1000_0000;
	localparam logic [9:0] K_DN_EDGE = 10'b00_0100_0000;
	localparam logic [9:0] K_TOP_A   = 10'b00_0010_0000;
	localparam logic [9:0] K_BOT_A   = 10'b00_0001_0000;
	localparam logic [9:0] K_TOP_B   = 10'b00_0000_1000;
	localparam logic [9:0] K_BOT_B   = 10'b00_0000_0100;
	localparam logic [9:0] K_PULSE_A = 10'b00_0000_0010;
	localparam logic [9:0] K_PULSE_B = 10'b00_0000_0001;

	localparam dmsl_pkg::rsp_t RSP_QUIET = '{dmsl_pkg::DRV_STOP, dmsl_pkg::DRV_STOP,
		1'b0, 1'b0, dmsl_pkg::PHASE_IDLE};

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                           kind;
		logic [9:0]                          bits;
		logic [dmsl_pkg::CFG_INDEX_BITS-1:0] idx;
		logic [dmsl_pkg::CFG_DATA_BITS-1:0]  val;
		logic                                typed;
		dmsl_pkg::rsp_t                      rsp;
	} row_t;

	localparam int DIR_ROWS = 30;
	localparam row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_TICK, 10'd0, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, K_UP_EDGE | K_UP_HELD, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_PULSE_A, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_PULSE_B, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, 10'd0, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_WRITE, 10'd0, dmsl_pkg::REG_DEBOUNCE_TICKS, 16'hFF00, 1'b0, RSP_QUIET},
		'{ROW_WRITE, 10'd0, dmsl_pkg::REG_BRAKE_TICKS, 16'd2, 1'b0, RSP_QUIET},
		'{ROW_WRITE, 10'd0, dmsl_pkg::REG_SYNC_THRESHOLD, 16'd1, 1'b0, RSP_QUIET},
		'{ROW_WRITE, 10'd0, REG_UNUSED, 16'hFFFF, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_EDGE, 2'd0, 16'd0, 1'b1, RSP_QUIET},
		'{ROW_TICK, K_UP_EDGE | K_DN_EDGE | K_UP_HELD | K_DN_HELD, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_PULSE_B, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_PULSE_B, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_PULSE_A, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_PULSE_A, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_UP_EDGE | K_TOP_A, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_UP_HELD | K_TOP_B | K_BOT_A, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_DN_HELD, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_DN_HELD, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_DN_HELD, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_DN_HELD, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_DN_HELD | K_BOT_B, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, 10'd0, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, 10'd0, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, 10'd0, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_WRITE, 10'd0, dmsl_pkg::REG_BRAKE_TICKS, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, K_DN_EDGE | K_DN_HELD, 2'd0, 16'd0, 1'b0, RSP_QUIET},
		'{ROW_TICK, 10'd0, 2'd0, 16'd0, 1'b1, RSP_QUIET}
	};

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	dmsl_pkg::req_t                      in_data;
	logic                                out_valid;
	logic                                out_stall;
	dmsl_pkg::rsp_t                      out_data;
	logic                                cfg_wr_en;
	logic [dmsl_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [dmsl_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	// predictor state and register copies
	logic [1:0]          lift_phase;
	logic                brake_up;
	logic [1:0]          drive_a;
	logic [1:0]          drive_b;
	logic [CNT_BITS-1:0] pulses_a;
	logic [CNT_BITS-1:0] pulses_b;
	logic [3:0]          limits;
	logic                up_armed;
	logic                down_armed;
	logic [15:0]         tick_wait;
	logic [15:0]         lead_limit;
	logic [15:0]         brake_len;
	logic [7:0]          debounce_len;

	dmsl_pkg::rsp_t lift_out_q [$];
	dmsl_pkg::rsp_t want;
	int   faults = 0;
	int   ticks_sent = 0;
	int   stall_left = 0;
	bit   calm = 1'b0;

	dual_motor_sync_lift_controller #(.COUNT_BITS(CNT_BITS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic halt_motors();
		drive_a = dmsl_pkg::DRV_STOP;
		drive_b = dmsl_pkg::DRV_STOP;
		lift_phase = dmsl_pkg::PHASE_IDLE;
		pulses_a = '0;
		pulses_b = '0;
		limits = '0;
		tick_wait = '0;
	endtask

	task automatic steer_motors();
		logic [1:0] dir;
		logic       lim_a;
		logic       lim_b;
		dir = (lift_phase == dmsl_pkg::PHASE_RAISE) ? dmsl_pkg::DRV_RAISE : dmsl_pkg::DRV_LOWER;
		lim_a = (lift_phase == dmsl_pkg::PHASE_RAISE) ? limits[0] : limits[1];
		lim_b = (lift_phase == dmsl_pkg::PHASE_RAISE) ? limits[2] : limits[3];
		if (lim_a && lim_b) begin
			drive_a = dmsl_pkg::DRV_STOP;
			drive_b = dmsl_pkg::DRV_STOP;
		end else if (lim_a) begin
			drive_a = dmsl_pkg::DRV_STOP;
		end else if (lim_b) begin
			drive_b = dmsl_pkg::DRV_STOP;
		end else if (pulses_a > pulses_b && pulses_a - pulses_b > lead_limit) begin
			drive_a = dmsl_pkg::DRV_STOP;
			drive_b = dir;
		end else if (pulses_b > pulses_a && pulses_b - pulses_a > lead_limit) begin
			drive_b = dmsl_pkg::DRV_STOP;
			drive_a = dir;
		end else if (pulses_a == pulses_b) begin
			drive_a = dir;
			drive_b = dir;
		end
	endtask

	task automatic start_brake();
		logic [1:0] rev;
		brake_up = (lift_phase == dmsl_pkg::PHASE_LOWER);
		rev = brake_up ? dmsl_pkg::DRV_RAISE : dmsl_pkg::DRV_LOWER;
		if (brake_len == 16'd0) begin
			halt_motors();
		end else begin
			drive_a = rev;
			drive_b = rev;
			tick_wait = brake_len;
			lift_phase = dmsl_pkg::PHASE_BRAKE;
		end
	endtask

	task automatic start_run(input logic [1:0] ph, input logic [1:0] dir);
		lift_phase = ph;
		drive_a = dir;
		drive_b = dir;
		steer_motors();
	endtask

	task automatic lift_step(input dmsl_pkg::req_t r, output dmsl_pkg::rsp_t o);
		if (r.up_key_edge) up_armed = 1'b1;
		if (r.down_key_edge) down_armed = 1'b1;
		limits = limits | {r.second_bottom_hit, r.second_top_hit,
			r.first_bottom_hit, r.first_top_hit};
		if (r.first_pulse && pulses_a != '1) pulses_a = pulses_a + 1'b1;
		if (r.second_pulse && pulses_b != '1) pulses_b = pulses_b + 1'b1;
		case (lift_phase)
			dmsl_pkg::PHASE_IDLE: begin
				if (up_armed || down_armed) begin
					if (tick_wait >= {8'd0, debounce_len}) begin
						tick_wait = '0;
						if (up_armed) begin
							if (r.up_key_held)
								start_run(dmsl_pkg::PHASE_RAISE, dmsl_pkg::DRV_RAISE);
							else up_armed = 1'b0;
						end else begin
							if (r.down_key_held)
								start_run(dmsl_pkg::PHASE_LOWER, dmsl_pkg::DRV_LOWER);
							else down_armed = 1'b0;
						end
					end else begin
						tick_wait = tick_wait + 1'b1;
					end
				end else begin
					tick_wait = '0;
				end
			end
			dmsl_pkg::PHASE_RAISE: begin
				if (!r.up_key_held) begin
					up_armed = 1'b0;
					start_brake();
				end else begin
					steer_motors();
				end
			end
			dmsl_pkg::PHASE_LOWER: begin
				if (!r.down_key_held) begin
					down_armed = 1'b0;
					start_brake();
				end else begin
					steer_motors();
				end
			end
			default: begin
				if (tick_wait <= 16'd1) halt_motors();
				else tick_wait = tick_wait - 1'b1;
			end
		endcase
		o.first_drive = drive_a;
		o.second_drive = drive_b;
		o.raise_lamp = (lift_phase == dmsl_pkg::PHASE_RAISE);
		o.lower_lamp = (lift_phase == dmsl_pkg::PHASE_LOWER);
		o.phase = lift_phase;
	endtask

	task automatic send_tick(input dmsl_pkg::req_t r, input logic typed,
			input dmsl_pkg::rsp_t typed_rsp);
		int             gap;
		dmsl_pkg::rsp_t p;
		gap = calm ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		lift_step(r, p);
		lift_out_q.push_back(typed ? typed_rsp : p);
		ticks_sent++;
	endtask

	task automatic await_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (lift_out_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dmsl_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [dmsl_pkg::CFG_DATA_BITS-1:0] val);
		await_results();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			dmsl_pkg::REG_SYNC_THRESHOLD: lead_limit = val;
			dmsl_pkg::REG_BRAKE_TICKS:    brake_len = val;
			dmsl_pkg::REG_DEBOUNCE_TICKS: debounce_len = val[7:0];
			default: ;
		endcase
	endtask

	// one key press: edge, hold past debounce (or drop early when broken), release, brake out
	task automatic lift_session(input bit broken);
		dmsl_pkg::req_t r;
		bit             go_up;
		int             rate_a;
		int             rate_b;
		int             hold_len;
		int             total;
		go_up = 1'($urandom_range(0, 1));
		rate_a = $urandom_range(0, 4);
		rate_b = $urandom_range(0, 4);
		if (broken) hold_len = $urandom_range(0, debounce_len);
		else hold_len = debounce_len + $urandom_range(2, 25);
		total = hold_len + brake_len + $urandom_range(1, 3);
		for (int k = 0; k < total; k++) begin
			r = dmsl_pkg::req_t'(10'd0);
			r.up_key_held = go_up ? (k < hold_len) : 1'($urandom_range(0, 1));
			r.down_key_held = go_up ? 1'($urandom_range(0, 1)) : (k < hold_len);
			r.up_key_edge = go_up ? (k == 0) : ($urandom_range(0, 29) == 0);
			r.down_key_edge = go_up ? ($urandom_range(0, 29) == 0) : (k == 0);
			r.first_top_hit = ($urandom_range(0, 39) == 0);
			r.first_bottom_hit = ($urandom_range(0, 39) == 0);
			r.second_top_hit = ($urandom_range(0, 39) == 0);
			r.second_bottom_hit = ($urandom_range(0, 39) == 0);
			r.first_pulse = ($urandom_range(0, 3) < rate_a);
			r.second_pulse = ($urandom_range(0, 3) < rate_b);
			send_tick(r, 1'b0, RSP_QUIET);
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (lift_out_q.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected result: drv %0d/%0d lamps %0d/%0d phase %0d",
						out_data.first_drive, out_data.second_drive,
						out_data.raise_lamp, out_data.lower_lamp, out_data.phase);
			end else begin
				want = lift_out_q.pop_front();
				if (out_data.first_drive !== want.first_drive ||
						out_data.second_drive !== want.second_drive ||
						out_data.raise_lamp !== want.raise_lamp ||
						out_data.lower_lamp !== want.lower_lamp ||
						out_data.phase !== want.phase) begin
					faults++;
					if (faults <= 10)
						$display("mismatch at %0t: want drv %0d/%0d lamps %0d/%0d phase %0d, %s",
							$realtime, want.first_drive, want.second_drive,
							want.raise_lamp, want.lower_lamp, want.phase,
							$sformatf("got drv %0d/%0d lamps %0d/%0d phase %0d",
								out_data.first_drive, out_data.second_drive,
								out_data.raise_lamp, out_data.lower_lamp, out_data.phase));
				end
			end
			stall_left = calm ? 0 : $urandom_range(0, 10);
		end
	end

	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		dmsl_pkg::req_t r;
		int             pick;
		int             base;
		logic [15:0]    lead_set;
		logic [15:0]    brake_set;
		logic [15:0]    deb_set;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = dmsl_pkg::req_t'(10'd0);
		out_stall = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		lead_limit = dmsl_pkg::SYNC_THRESHOLD_RESET;
		brake_len = dmsl_pkg::BRAKE_TICKS_RESET;
		debounce_len = dmsl_pkg::DEBOUNCE_TICKS_RESET;
		brake_up = 1'b0;
		up_armed = 1'b0;
		down_armed = 1'b0;
		halt_motors();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_ROWS; k++) begin
			if (DIR_TAB[k].kind == ROW_WRITE)
				write_reg(DIR_TAB[k].idx, DIR_TAB[k].val);
			else
				send_tick(dmsl_pkg::req_t'(DIR_TAB[k].bits), DIR_TAB[k].typed, DIR_TAB[k].rsp);
		end

		// run at zero lead from unequal counts, then ride out a long brake
		write_reg(dmsl_pkg::REG_SYNC_THRESHOLD, 16'd0);
		write_reg(dmsl_pkg::REG_BRAKE_TICKS, 16'd120);
		write_reg(dmsl_pkg::REG_DEBOUNCE_TICKS, 16'h1203);
		calm = 1'b1;
		for (int k = 0; k < 20; k++) begin
			r = dmsl_pkg::req_t'(K_PULSE_A);
			r.second_pulse = (k >= 5);
			send_tick(r, 1'b0, RSP_QUIET);
		end
		for (int k = 0; k < 40; k++) begin
			r = dmsl_pkg::req_t'(K_UP_HELD | K_PULSE_B);
			r.up_key_edge = (k == 0);
			r.first_pulse = k[0];
			send_tick(r, 1'b0, RSP_QUIET);
		end
		for (int k = 0; k < 125; k++) begin
			r = dmsl_pkg::req_t'(10'($urandom));
			r.up_key_edge = 1'b0;
			r.down_key_edge = 1'b0;
			if (k == 0) r.up_key_held = 1'b0;
			send_tick(r, 1'b0, RSP_QUIET);
		end
		calm = 1'b0;

		for (int s = 0; s < 4; s++) begin
			case (s)
				0: begin
					lead_set = 16'd0;
					brake_set = 16'd0;
					deb_set = 16'd0;
				end
				1: begin
					lead_set = 16'd2;
					brake_set = 16'd3;
					deb_set = 16'd1;
				end
				2: begin
					lead_set = 16'hFFFF;
					brake_set = 16'd1;
					deb_set = 16'd3;
				end
				default: begin
					lead_set = 16'($urandom_range(0, 6));
					brake_set = 16'($urandom_range(0, 8));
					deb_set = {8'($urandom), 8'($urandom_range(0, 4))};
				end
			endcase
			write_reg(dmsl_pkg::REG_SYNC_THRESHOLD, lead_set);
			write_reg(dmsl_pkg::REG_BRAKE_TICKS, brake_set);
			write_reg(dmsl_pkg::REG_DEBOUNCE_TICKS, deb_set);
			base = ticks_sent;
			while (ticks_sent - base < 145) begin
				pick = $urandom_range(0, 99);
				calm = ($urandom_range(0, 5) == 0);
				if (pick < 75) begin
					lift_session(1'b0);
				end else if (pick < 88) begin
					lift_session(1'b1);
				end else begin
					repeat ($urandom_range(1, 5))
						send_tick(dmsl_pkg::req_t'(10'($urandom)), 1'b0, RSP_QUIET);
				end
				// hold off until every pending request has its result
				if ($urandom_range(0, 39) == 0) await_results();
			end
		end
		calm = 1'b0;

		await_results();
		repeat (10) @(posedge clk);
		if (faults == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
